FILE: sv/pfm_pkg.sv
// Shared types and constants of the pulse flow meter.
package pfm_pkg;

  localparam int CMD_W     = 2;
  localparam int TS_W      = 32;
  localparam int RATE_W    = 20;
  localparam int VOL_W     = 32;
  localparam int TOTAL_W   = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SCALE_W   = 28;
  localparam int DEN_W     = 48;
  localparam int QUOT_W    = 32;
  localparam int QDEPTH    = 2;

  // 1e6 * 256 for the rate, 1000 * 256 for the volume
  localparam logic [SCALE_W-1:0] RATE_SCALE = 28'd256000000;
  localparam logic [SCALE_W-1:0] VOL_SCALE  = 28'd256000;

  localparam logic [15:0] DEBOUNCE_RST   = 16'd1500;
  localparam logic [15:0] MIN_WINDOW_RST = 16'd500;
  localparam logic [15:0] CAL_RST        = 16'd1920;
  localparam logic [23:0] PPL_RST        = 24'd115200;
  localparam logic [15:0] ZERO_TH_RST    = 16'd50;

  typedef enum logic [CMD_W-1:0] {
    CMD_PULSE  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 3'd0,
    REG_MIN_WINDOW = 3'd1,
    REG_CAL        = 3'd2,
    REG_PPL        = 3'd3,
    REG_ZERO_TH    = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    cmd_t            kind;
    logic [TS_W-1:0] ts;
  } item_t;

  typedef struct packed {
    logic [15:0] debounce_us;
    logic [15:0] min_window_ms;
    logic [15:0] cal_q8;
    logic [23:0] ppl_q8;
    logic [15:0] zero_th;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic start;
    logic wide;
  } div_req_t;

endpackage

FILE: sv/pfm_fifo.sv
// Short queue of classified items between the front and back parts.
module pfm_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  pfm_pkg::item_t     push_item,
  input  logic               pop,
  output pfm_pkg::item_t     head,
  output pfm_pkg::q_status_t status
);

  localparam int PTR_W = (pfm_pkg::QDEPTH > 1) ? $clog2(pfm_pkg::QDEPTH) : 1;
  localparam int CNT_W = $clog2(pfm_pkg::QDEPTH + 1);

  pfm_pkg::item_t   mem [pfm_pkg::QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(pfm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(pfm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head         = mem[rd_ptr];
  assign status.full  = (count == CNT_W'(pfm_pkg::QDEPTH));
  assign status.empty = (count == '0);

endmodule

FILE: sv/pfm_div.sv
// Iterative restoring divider with a saturating 20- or 32-bit quotient.
module pfm_div #(
  parameter int NUM_W = 60
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pfm_pkg::div_req_t          req,
  input  logic [NUM_W-1:0]           num,
  input  logic [pfm_pkg::DEN_W-1:0]  den,
  output logic                       done,
  output logic [pfm_pkg::QUOT_W-1:0] quot
);

  localparam int DW    = pfm_pkg::DEN_W;
  localparam int QW    = pfm_pkg::QUOT_W;
  localparam int RW    = pfm_pkg::RATE_W;
  localparam int CMP_W = (NUM_W > DW + QW) ? NUM_W : DW + QW;
  localparam int EXT_W = (NUM_W > DW) ? NUM_W : DW;
  localparam int CNT_W = $clog2(QW + 1);

  typedef enum logic {D_IDLE, D_RUN} dstate_t;

  dstate_t          state;
  logic [DW-1:0]    den_r;
  logic [DW-1:0]    rem;
  logic [QW-1:0]    low;
  logic [CNT_W-1:0] cnt;

  logic [CMP_W-1:0] num_cmp;
  logic [CMP_W-1:0] den_lim;
  logic             overflow;
  logic [EXT_W-1:0] num_ext;
  logic [EXT_W-1:0] rem_wide;
  logic [QW-1:0]    low_init;
  logic [QW-1:0]    qmax;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             fits;

  always_comb begin
    num_cmp  = CMP_W'(num);
    den_lim  = req.wide ? (CMP_W'(den) << QW) : (CMP_W'(den) << RW);
    // quotient would not fit the requested width
    overflow = (num_cmp >= den_lim);
    num_ext  = EXT_W'(num);
    rem_wide = req.wide ? (num_ext >> QW) : (num_ext >> RW);
    low_init = req.wide ? num[QW-1:0] : {num[RW-1:0], {(QW - RW){1'b0}}};
    qmax     = req.wide ? '1 : QW'({RW{1'b1}});
    trial    = {rem, low[QW-1]};
    diff     = trial - {1'b0, den_r};
    fits     = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          if (req.start) begin
            den_r <= den;
            if (den == '0) begin
              quot <= (num != '0) ? qmax : '0;
              done <= 1'b1;
            end else if (overflow) begin
              quot <= qmax;
              done <= 1'b1;
            end else begin
              done  <= 1'b0;
              rem   <= rem_wide[DW-1:0];
              low   <= low_init;
              quot  <= '0;
              cnt   <= req.wide ? CNT_W'(QW) : CNT_W'(RW);
              state <= D_RUN;
            end
          end else begin
            done <= 1'b0;
          end
        end
        D_RUN: begin
          rem  <= fits ? diff[DW-1:0] : trial[DW-1:0];
          low  <= {low[QW-2:0], 1'b0};
          quot <= {quot[QW-2:0], fits};
          cnt  <= cnt - 1'b1;
          done <= (cnt == CNT_W'(1));
          if (cnt == CNT_W'(1)) begin
            state <= D_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= D_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: sv/pfm_back.sv
// Back part: counters, window closing, rate and volume computation, result register.
module pfm_back #(
  parameter int COUNT_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  pfm_pkg::cfg_t               cfg,
  input  pfm_pkg::item_t              head,
  input  pfm_pkg::q_status_t          qs,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [pfm_pkg::RATE_W-1:0]  flow_rate_mlpm,
  output logic [pfm_pkg::VOL_W-1:0]   volume_ml,
  output logic                        rate_updated,
  output logic [pfm_pkg::TOTAL_W-1:0] total_pulse_count
);

  localparam int SW     = pfm_pkg::SCALE_W;
  localparam int DW     = pfm_pkg::DEN_W;
  localparam int TSW    = pfm_pkg::TS_W;
  localparam int RW     = pfm_pkg::RATE_W;
  localparam int TOTW   = pfm_pkg::TOTAL_W;
  localparam int HALF   = (COUNT_BITS + 1) / 2;
  localparam int PROD_W = HALF + SW;
  localparam int NUM_W  = COUNT_BITS + SW;
  localparam int TW     = (COUNT_BITS > TOTW) ? COUNT_BITS : TOTW;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_LO, S_MUL_HI, S_MUL_SUM, S_DIV_WAIT, S_DONE
  } bstate_t;

  bstate_t                state;
  logic [COUNT_BITS-1:0]  window_pulses;
  logic [COUNT_BITS-1:0]  total_pulses;
  logic [TSW-1:0]         last_pulse_us;
  logic [TSW-1:0]         last_sample_ms;
  logic [RW-1:0]          held_rate;
  logic                   updated;
  logic                   vol_phase;
  logic [COUNT_BITS-1:0]  mul_op;
  logic [TSW-1:0]         elapsed_r;
  logic [PROD_W-1:0]      prod_lo;
  logic [PROD_W-1:0]      prod_hi;
  logic [NUM_W-1:0]       num_r;
  logic [DW-1:0]          den_r;
  logic [pfm_pkg::VOL_W-1:0] vol_r;
  pfm_pkg::div_req_t      div_req;

  logic                   div_done;
  logic [pfm_pkg::QUOT_W-1:0] quot;

  logic [TSW-1:0]         pulse_gap;
  logic [TSW-1:0]         elapsed;
  logic [COUNT_BITS:0]    total_sum;
  logic [SW-1:0]          mul_k;
  logic [PROD_W-1:0]      mul_lo;
  logic [PROD_W-1:0]      mul_hi;
  logic [DW-1:0]          den_rate;
  logic [RW-1:0]          rate_val;
  logic [TW-1:0]          total_ext;
  logic [TOTW-1:0]        total_sat;

  always_comb begin
    pop       = (state == S_IDLE) && !qs.empty;
    pulse_gap = head.ts - last_pulse_us;
    elapsed   = head.ts - last_sample_ms;
    total_sum = {1'b0, total_pulses} + {1'b0, window_pulses};
    mul_k     = vol_phase ? pfm_pkg::VOL_SCALE : pfm_pkg::RATE_SCALE;
    mul_lo    = PROD_W'(mul_op[HALF-1:0]) * PROD_W'(mul_k);
    mul_hi    = PROD_W'(mul_op[COUNT_BITS-1:HALF]) * PROD_W'(mul_k);
    den_rate  = DW'(elapsed_r) * DW'(cfg.cal_q8);
    rate_val  = (quot[RW-1:0] < RW'(cfg.zero_th)) ? '0 : quot[RW-1:0];
    total_ext = TW'(total_pulses);
    total_sat = (total_ext > TW'({TOTW{1'b1}})) ? '1 : total_ext[TOTW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      window_pulses  <= '0;
      total_pulses   <= '0;
      last_pulse_us  <= '0;
      last_sample_ms <= '0;
      held_rate      <= '0;
      div_req        <= '0;
      out_valid      <= 1'b0;
    end else begin
      div_req.start <= (state == S_MUL_SUM);
      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (!qs.empty) begin
            case (head.kind)
              pfm_pkg::CMD_PULSE: begin
                if (pulse_gap >= TSW'(cfg.debounce_us)) begin
                  last_pulse_us <= head.ts;
                  if (window_pulses != '1) begin
                    window_pulses <= window_pulses + 1'b1;
                  end
                end
              end
              pfm_pkg::CMD_CLEAR: begin
                total_pulses <= '0;
              end
              pfm_pkg::CMD_SAMPLE: begin
                state <= S_MUL_LO;
                if (elapsed >= TSW'(cfg.min_window_ms)) begin
                  // close the window: rate first, then volume
                  updated        <= 1'b1;
                  vol_phase      <= 1'b0;
                  mul_op         <= window_pulses;
                  window_pulses  <= '0;
                  last_sample_ms <= head.ts;
                  total_pulses   <= total_sum[COUNT_BITS] ? '1
                                                          : total_sum[COUNT_BITS-1:0];
                  elapsed_r      <= (elapsed == '0) ? TSW'(1) : elapsed;
                end else begin
                  updated   <= 1'b0;
                  vol_phase <= 1'b1;
                  mul_op    <= total_pulses;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL_LO: begin
          prod_lo <= mul_lo;
          den_r   <= vol_phase ? DW'(cfg.ppl_q8) : den_rate;
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= mul_hi;
          state   <= S_MUL_SUM;
        end
        S_MUL_SUM: begin
          num_r        <= NUM_W'(prod_lo) + (NUM_W'(prod_hi) << HALF);
          div_req.wide <= vol_phase;
          state        <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (!vol_phase) begin
              held_rate <= rate_val;
              vol_phase <= 1'b1;
              mul_op    <= total_pulses;
              state     <= S_MUL_LO;
            end else begin
              vol_r <= quot;
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            flow_rate_mlpm    <= held_rate;
            volume_ml         <= vol_r;
            rate_updated      <= updated;
            total_pulse_count <= total_sat;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pfm_div #(
    .NUM_W(NUM_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (num_r),
    .den  (den_r),
    .done (div_done),
    .quot (quot)
  );

endmodule

FILE: sv/pulse_flow_meter.sv
// Pulse flow meter top level: configuration registers, item classifier, queue, back part.
//
// Input channel (in_valid / in_stall): one transaction per command. cmd 0 carries a
// pulse edge with pulse_time_us, cmd 1 a sample request with sample_time_ms, cmd 2
// clears the total count. Code 3 is accepted and dropped. The front classifies each
// transaction into a two-entry queue and stalls only when that queue is full.
// Output channel (out_valid / out_stall): one result per sample request, carrying rate,
// volume, the rate_updated flag and the total count.
// Processing: pulse and clear commands are handled as they leave the queue. A sample
// request that closes a window computes the rate and then the volume (two multiplies,
// each split into low, high and sum steps, a 20-step rate divide and a 32-step volume
// divide on one shared restoring divider); a short window computes the volume only.
// The divider sets the sample rate.
// When the receiver stalls, the result is held in the output register; the back part
// keeps taking pulse and clear commands and waits only when a second result is ready.
// Reset (rst, synchronous) loads the register defaults, clears counters, timestamps,
// held rate and the queue. The user must write configuration (cfg_write / cfg_index /
// cfg_data) only while no transaction is in flight; the block itself does not enforce it.
module pulse_flow_meter #(
  parameter int COUNT_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pfm_pkg::CMD_W-1:0]     cmd,
  input  logic [pfm_pkg::TS_W-1:0]      pulse_time_us,
  input  logic [pfm_pkg::TS_W-1:0]      sample_time_ms,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pfm_pkg::RATE_W-1:0]    flow_rate_mlpm,
  output logic [pfm_pkg::VOL_W-1:0]     volume_ml,
  output logic                          rate_updated,
  output logic [pfm_pkg::TOTAL_W-1:0]   total_pulse_count,
  input  logic                          cfg_write,
  input  logic [pfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pfm_pkg::CFG_W-1:0]     cfg_data
);

  pfm_pkg::cfg_t      cfg;
  pfm_pkg::item_t     push_item;
  pfm_pkg::item_t     head;
  pfm_pkg::q_status_t qs;
  logic               push;
  logic               known_cmd;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_us   <= pfm_pkg::DEBOUNCE_RST;
      cfg.min_window_ms <= pfm_pkg::MIN_WINDOW_RST;
      cfg.cal_q8        <= pfm_pkg::CAL_RST;
      cfg.ppl_q8        <= pfm_pkg::PPL_RST;
      cfg.zero_th       <= pfm_pkg::ZERO_TH_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        pfm_pkg::REG_DEBOUNCE:   cfg.debounce_us   <= cfg_data[15:0];
        pfm_pkg::REG_MIN_WINDOW: cfg.min_window_ms <= cfg_data[15:0];
        pfm_pkg::REG_CAL:        cfg.cal_q8        <= cfg_data[15:0];
        pfm_pkg::REG_PPL:        cfg.ppl_q8        <= cfg_data[23:0];
        pfm_pkg::REG_ZERO_TH:    cfg.zero_th       <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // classify: pick the timestamp that goes with the command, drop the unused code
  always_comb begin
    known_cmd      = 1'b1;
    push_item.kind = pfm_pkg::CMD_PULSE;
    push_item.ts   = pulse_time_us;
    case (cmd)
      pfm_pkg::CMD_PULSE: begin
        push_item.kind = pfm_pkg::CMD_PULSE;
        push_item.ts   = pulse_time_us;
      end
      pfm_pkg::CMD_SAMPLE: begin
        push_item.kind = pfm_pkg::CMD_SAMPLE;
        push_item.ts   = sample_time_ms;
      end
      pfm_pkg::CMD_CLEAR: begin
        push_item.kind = pfm_pkg::CMD_CLEAR;
        push_item.ts   = sample_time_ms;
      end
      default: known_cmd = 1'b0;
    endcase
  end

  assign in_stall = qs.full;
  assign push     = in_valid && !qs.full && known_cmd;

  pfm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .status    (qs)
  );

  pfm_back #(
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .head              (head),
    .qs                (qs),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .flow_rate_mlpm    (flow_rate_mlpm),
    .volume_ml         (volume_ml),
    .rate_updated      (rate_updated),
    .total_pulse_count (total_pulse_count)
  );

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for pulse_flow_meter: directed corners, then random flow traffic.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [pfm_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;
  localparam int SETTLE_CYCLES = 150;
  localparam int IDLE_LIMIT = 5000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 230;

  typedef struct {
    logic [pfm_pkg::RATE_W-1:0]  rate;
    logic [pfm_pkg::VOL_W-1:0]   vol;
    logic                        updated;
    logic [pfm_pkg::TOTAL_W-1:0] total;
  } reading_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic [pfm_pkg::CMD_W-1:0]     cmd;
  logic [pfm_pkg::TS_W-1:0]      pulse_time_us;
  logic [pfm_pkg::TS_W-1:0]      sample_time_ms;
  logic                          out_valid;
  logic                          out_stall;
  logic [pfm_pkg::RATE_W-1:0]    flow_rate_mlpm;
  logic [pfm_pkg::VOL_W-1:0]     volume_ml;
  logic                          rate_updated;
  logic [pfm_pkg::TOTAL_W-1:0]   total_pulse_count;
  logic                          cfg_write;
  logic [pfm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pfm_pkg::CFG_W-1:0]     cfg_data;

  // predictor state and register copies
  logic [15:0] set_debounce = pfm_pkg::DEBOUNCE_RST;
  logic [15:0] set_window = pfm_pkg::MIN_WINDOW_RST;
  logic [15:0] set_cal = pfm_pkg::CAL_RST;
  logic [23:0] set_ppl = pfm_pkg::PPL_RST;
  logic [15:0] set_zero_th = pfm_pkg::ZERO_TH_RST;
  logic [31:0] win_count = '0;
  logic [31:0] last_edge_us = '0;
  logic [31:0] last_sample_at = '0;
  logic [31:0] total_count = '0;
  logic [pfm_pkg::RATE_W-1:0] held_rate = '0;

  reading_t due_readings[$];
  reading_t want;
  int mismatches = 0;
  int dead_cycles = 0;
  bit quiet = 1'b0;

  pulse_flow_meter i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .cmd(cmd),
    .pulse_time_us(pulse_time_us),
    .sample_time_ms(sample_time_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .flow_rate_mlpm(flow_rate_mlpm),
    .volume_ml(volume_ml),
    .rate_updated(rate_updated),
    .total_pulse_count(total_pulse_count),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // floor(num / den) clipped to qbits; a zero divisor gives all ones unless num is zero
  function automatic logic [63:0] sat_quotient(input logic [63:0] num, input logic [63:0] den,
                                               input int qbits);
    logic [63:0] qmax;
    logic [63:0] q;
    qmax = (64'd1 << qbits) - 64'd1;
    if (den == 64'd0) return (num != 64'd0) ? qmax : 64'd0;
    q = num / den;
    return (q > qmax) ? qmax : q;
  endfunction

  task automatic track_command(input logic [1:0] c, input logic [31:0] us,
                               input logic [31:0] ms);
    logic [31:0] delta;
    logic [31:0] pulses;
    logic [32:0] sum;
    logic [63:0] quot;
    reading_t r;
    r.updated = 1'b0;
    case (c)
      pfm_pkg::CMD_PULSE: begin
        delta = us - last_edge_us;
        if (delta >= {16'd0, set_debounce}) begin
          last_edge_us = us;
          if (win_count != COUNT_MAX) win_count = win_count + 32'd1;
        end
      end
      pfm_pkg::CMD_CLEAR: total_count = '0;
      pfm_pkg::CMD_SAMPLE: begin
        delta = ms - last_sample_at;
        if (delta >= {16'd0, set_window}) begin
          pulses = win_count;
          win_count = '0;
          last_sample_at = ms;
          sum = {1'b0, total_count} + {1'b0, pulses};
          total_count = sum[32] ? COUNT_MAX : sum[31:0];
          if (delta == 32'd0) delta = 32'd1;
          quot = sat_quotient({32'd0, pulses} * {36'd0, pfm_pkg::RATE_SCALE},
                              {32'd0, delta} * {48'd0, set_cal}, pfm_pkg::RATE_W);
          if (quot < {48'd0, set_zero_th}) quot = '0;
          held_rate = quot[pfm_pkg::RATE_W-1:0];
          r.updated = 1'b1;
        end
        quot = sat_quotient({32'd0, total_count} * {36'd0, pfm_pkg::VOL_SCALE},
                            {40'd0, set_ppl}, pfm_pkg::VOL_W);
        r.rate = held_rate;
        r.vol = quot[pfm_pkg::VOL_W-1:0];
        r.total = total_count;
        due_readings.push_back(r);
      end
      default: ;
    endcase
  endtask

  // mostly short idle runs, now and then a long one
  function automatic int idle_run();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [23:0] pick_setting(input logic [23:0] lo, hi, typ_lo, typ_hi);
    int r;
    r = $urandom_range(0, 5);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return 24'($urandom_range(typ_lo, typ_hi));
  endfunction

  // valid stays high after a transaction; the next call either replaces the payload or idles
  task automatic send_command(input logic [1:0] c, input logic [31:0] us, input logic [31:0] ms);
    int gap;
    gap = idle_run();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    pulse_time_us <= us;
    sample_time_ms <= ms;
    do @(posedge clk); while (in_stall);
    track_command(c, us, ms);
  endtask

  // pulse and clear transactions give no reading, so allow the back part time to finish them
  task automatic drain_meter();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input pfm_pkg::cfg_reg_t idx, input logic [23:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      pfm_pkg::REG_DEBOUNCE:   set_debounce = val[15:0];
      pfm_pkg::REG_MIN_WINDOW: set_window = val[15:0];
      pfm_pkg::REG_CAL:        set_cal = val[15:0];
      pfm_pkg::REG_PPL:        set_ppl = val;
      pfm_pkg::REG_ZERO_TH:    set_zero_th = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_meter(input logic [23:0] deb, win, cal, ppl, zth);
    drain_meter();
    write_reg(pfm_pkg::REG_DEBOUNCE, deb);
    write_reg(pfm_pkg::REG_MIN_WINDOW, win);
    write_reg(pfm_pkg::REG_CAL, cal);
    write_reg(pfm_pkg::REG_PPL, ppl);
    write_reg(pfm_pkg::REG_ZERO_TH, zth);
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // reset defaults: early edges rejected, short window, window of exactly the minimum
  task automatic test_reset_state();
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'd100);
    send_command(pfm_pkg::CMD_PULSE, 32'd100, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'd1500, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'd2999, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'd3000, 32'd0);
    send_command(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'd500);
  endtask

  // zero debounce and window, unit calibration: equal stamps, zero elapsed, saturation, wrap
  task automatic test_low_settings();
    program_meter(24'd0, 24'd0, 24'd1, 24'd1, 24'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'hFFFF_FFFF, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'hFFFF_FFFF, 32'd0);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'd500);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'd500);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'hFFFF_FFF0);
    send_command(pfm_pkg::CMD_PULSE, 32'd0, 32'd0);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'h0000_0010);
  endtask

  // all registers at their top values; edges and samples under and at the debounce and window limits
  task automatic test_high_settings();
    program_meter(24'd65535, 24'd65535, 24'd65535, 24'hFF_FFFF, 24'd65535);
    send_command(pfm_pkg::CMD_PULSE, 32'h0000_8000, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'h0001_0000, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'h0001_FFFF, 32'd0);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'h0000_0010 + 32'd65534);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'h0000_0010 + 32'd65535);
    send_command(pfm_pkg::CMD_CLEAR, 32'd0, 32'd0);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'h0000_0010 + 32'd65536);
  endtask

  // a clear in the middle of an open window keeps the window count
  task automatic test_clear_mid_window();
    program_meter(24'd1500, 24'd500, 24'd1920, 24'd115200, 24'd4000);
    send_command(pfm_pkg::CMD_PULSE, 32'h0010_0000, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'h0010_0000 + 32'd2000, 32'd0);
    send_command(pfm_pkg::CMD_CLEAR, 32'd0, 32'd0);
    send_command(pfm_pkg::CMD_PULSE, 32'h0010_0000 + 32'd4000, 32'd0);
    send_command(pfm_pkg::CMD_SAMPLE, 32'd0, 32'h0001_0010 + 32'd1000);
  endtask

  // bursts of edges followed by a sample, with some noise, clears and broken timing mixed in
  task automatic test_random_traffic();
    logic [31:0] us_clock;
    logic [31:0] ms_clock;
    logic [1:0] code;
    int n;
    int pulses;
    int r;
    int unsigned d;
    int unsigned w;
    int unsigned step;
    for (int p = 0; p < PHASES; p++) begin
      program_meter(pick_setting(24'd0, 24'd65535, 24'd0, 24'd3000),
                    pick_setting(24'd0, 24'd65535, 24'd0, 24'd1000),
                    pick_setting(24'd1, 24'd65535, 24'd200, 24'd4000),
                    pick_setting(24'd1, 24'hFF_FFFF, 24'd20000, 24'd500000),
                    pick_setting(24'd0, 24'd65535, 24'd0, 24'd300));
      quiet = (p == 2);
      us_clock = $urandom_range(0, 1) ? $urandom : COUNT_MAX - $urandom_range(0, 300000);
      ms_clock = $urandom_range(0, 1) ? $urandom : COUNT_MAX - $urandom_range(0, 300000);
      n = 0;
      while (n < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          code = 2'($urandom_range(0, 3));
          send_command(code, $urandom, $urandom);
          if (code != CMD_UNUSED) n++;
        end else if (r < 11) begin
          send_command(pfm_pkg::CMD_CLEAR, $urandom, $urandom);
          n++;
        end else if (r < 13) begin
          send_command(CMD_UNUSED, $urandom, $urandom);
        end else begin
          d = set_debounce;
          w = set_window;
          pulses = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
          repeat (pulses) begin
            r = $urandom_range(0, 99);
            if (r < 75) step = d + $urandom_range(0, d / 2 + 200);
            else if (r < 85) step = d;
            else step = $urandom_range(0, d);
            us_clock = us_clock + step;
            send_command(pfm_pkg::CMD_PULSE, us_clock, $urandom);
          end
          r = $urandom_range(0, 99);
          if (r < 75) step = w + $urandom_range(0, w / 4 + 50);
          else if (r < 85) step = w;
          else if (r < 95 && w > 0) step = $urandom_range(0, w - 1);
          else step = w + $urandom_range(0, 20000);
          ms_clock = ms_clock + step;
          send_command(pfm_pkg::CMD_SAMPLE, $urandom, ms_clock);
          n += pulses + 1;
        end
      end
    end
    quiet = 1'b0;
  endtask

  // receiver: free stretches, some of them long, between stall runs
  initial begin : stall_gen
    int free_run;
    int busy_run;
    out_stall = 1'b0;
    forever begin
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 12);
      repeat (free_run) begin
        @(negedge clk);
        out_stall <= 1'b0;
      end
      busy_run = idle_run();
      repeat (busy_run) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic compare_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] got);
    if (exp_val !== got) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (due_readings.size() == 0) begin
        $error("reading with none due: rate %0d volume %0d total %0d",
               flow_rate_mlpm, volume_ml, total_pulse_count);
        mismatches++;
      end else begin
        want = due_readings.pop_front();
        compare_field("flow_rate_mlpm", 32'(want.rate), 32'(flow_rate_mlpm));
        compare_field("volume_ml", want.vol, volume_ml);
        compare_field("rate_updated", 32'(want.updated), 32'(rate_updated));
        compare_field("total_pulse_count", want.total, total_pulse_count);
      end
    end
  end

  // watchdog: too long without a transaction on either side
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      dead_cycles <= 0;
    end else if (dead_cycles >= IDLE_LIMIT) begin
      $display("pulse_flow_meter regression: fail");
      $finish;
    end else begin
      dead_cycles <= dead_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    cmd = pfm_pkg::CMD_PULSE;
    pulse_time_us = '0;
    sample_time_ms = '0;
    cfg_write = 1'b0;
    cfg_index = pfm_pkg::REG_DEBOUNCE;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_low_settings();
    test_high_settings();
    test_clear_mid_window();
    test_random_traffic();
    drain_meter();
    if (mismatches == 0 && due_readings.size() == 0) begin
      $display("pulse_flow_meter regression: pass");
    end else begin
      $display("pulse_flow_meter regression: fail");
    end
    $finish;
  end

endmodule
